/* design/cbb_pkg.sv */
// shared types, constants and the arctangent table for the compass bearing block
// no dependencies
package cbb_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_BITS_DEF   = 16;

  localparam int COORD_BITS  = 32;
  localparam int DIFF_BITS   = COORD_BITS + 1;
  localparam int GUARD_SHIFT = 24;
  localparam int TURN_BITS   = 32;
  // magnitudes below 2^32, shifted by the guard bits, grow by at most ~2.33 in cordic
  localparam int CW          = COORD_BITS + GUARD_SHIFT + 4;
  // sum of all table entries stays below 2^31
  localparam int ZW          = TURN_BITS + 1;

  localparam logic [TURN_BITS-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [TURN_BITS-1:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [TURN_BITS-1:0] THREE_QUARTER_TURN = 32'hC000_0000;

  // direction class of the difference vector
  typedef enum logic [3:0] {
    CLS_SAME,
    CLS_N,
    CLS_E,
    CLS_S,
    CLS_W,
    CLS_NE,
    CLS_SE,
    CLS_SW,
    CLS_NW
  } cls_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    cls_t                 cls;
  } cordic_t;

  // round(atan(2^-i) / (2 pi) * 2^32)
  function automatic logic [TURN_BITS-1:0] atan_turn(input int unsigned i);
    logic [TURN_BITS-1:0] v;
    case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      28: v = 32'd3;
      29: v = 32'd1;
      30: v = 32'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* design/cbb_pts_if.sv */
// channel carrying one target/current point pair
// depends on cbb_pkg
interface cbb_pts_if;
  import cbb_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] target_x;
  logic signed [COORD_BITS-1:0] target_y;
  logic signed [COORD_BITS-1:0] current_x;
  logic signed [COORD_BITS-1:0] current_y;

  modport source (output valid, target_x, target_y, current_x, current_y, input ready);
  modport sink   (input valid, target_x, target_y, current_x, current_y, output ready);
endinterface

/* design/cbb_brg_if.sv */
// channel carrying one bearing result
// depends on cbb_pkg for the default angle width
interface cbb_brg_if #(
  parameter int ANGLE_BITS = cbb_pkg::ANGLE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] bearing;
  logic                  same_point;

  modport source (output valid, bearing, same_point, input ready);
  modport sink   (input valid, bearing, same_point, output ready);
endinterface

/* design/cbb_front.sv */
// front end: coordinate differences, direction class and first-quadrant fold
// depends on cbb_pkg and cbb_pts_if
module cbb_front (
  input  logic            clk,
  input  logic            rst,
  cbb_pts_if.sink         points,
  output logic            dn_valid,
  output cbb_pkg::cordic_t dn_data,
  input  logic            dn_ready
);
  import cbb_pkg::*;

  // stage 1: differences
  logic                        v1;
  logic signed [DIFF_BITS-1:0] dx;
  logic signed [DIFF_BITS-1:0] dy;
  logic                        adv1;

  // stage 2: folded vector
  logic    v2;
  cordic_t d2;
  logic    adv2;

  logic                        dx_zero, dy_zero, dx_neg, dy_neg;
  logic signed [DIFF_BITS-1:0] ax, ay;
  cls_t                        cls;
  cordic_t                     d2_next;

  assign adv2 = !v2 || dn_ready;
  assign adv1 = !v1 || adv2;
  // no word taken while in reset, it would be dropped with the valid bits
  assign points.ready = adv1 && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= points.valid;
    end
    if (adv1) begin
      dx <= $signed({points.target_x[COORD_BITS-1], points.target_x})
          - $signed({points.current_x[COORD_BITS-1], points.current_x});
      dy <= $signed({points.target_y[COORD_BITS-1], points.target_y})
          - $signed({points.current_y[COORD_BITS-1], points.current_y});
    end
  end

  always_comb begin
    dx_zero = (dx == '0);
    dy_zero = (dy == '0);
    dx_neg  = dx[DIFF_BITS-1];
    dy_neg  = dy[DIFF_BITS-1];
    ax = dx_neg ? -dx : dx;
    ay = dy_neg ? -dy : dy;
    if (dx_zero && dy_zero) begin
      cls = CLS_SAME;
    end else if (dx_zero) begin
      cls = dy_neg ? CLS_S : CLS_N;
    end else if (dy_zero) begin
      cls = dx_neg ? CLS_W : CLS_E;
    end else if (!dx_neg) begin
      cls = dy_neg ? CLS_SE : CLS_NE;
    end else begin
      cls = dy_neg ? CLS_SW : CLS_NW;
    end
    // cordic x starts on |dy|, y on |dx|
    d2_next.x   = $signed(CW'(ay[COORD_BITS-1:0]) << GUARD_SHIFT);
    d2_next.y   = $signed(CW'(ax[COORD_BITS-1:0]) << GUARD_SHIFT);
    d2_next.z   = '0;
    d2_next.cls = cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
    if (adv2) begin
      d2 <= d2_next;
    end
  end

  assign dn_valid = v2;
  assign dn_data  = d2;

  a_quadrant_positive: assert property (@(posedge clk) disable iff (rst)
    v2 && (d2.cls == CLS_NE || d2.cls == CLS_SE || d2.cls == CLS_SW || d2.cls == CLS_NW)
      |-> (d2.x > 0) && (d2.y > 0))
    else $error("folded vector not strictly inside first quadrant");

endmodule

/* design/cbb_cordic_stage.sv */
// one cordic vectoring iteration with its own valid and stall handling
// depends on cbb_pkg
module cbb_cordic_stage #(
  parameter int unsigned STEP = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  input  cbb_pkg::cordic_t up_data,
  output logic             up_ready,
  output logic             dn_valid,
  output cbb_pkg::cordic_t dn_data,
  input  logic             dn_ready
);
  import cbb_pkg::*;

  logic    v;
  cordic_t d;
  cordic_t d_next;
  logic    adv;

  logic signed [CW-1:0] xi, yi, xs, ys;
  logic signed [ZW-1:0] zi, za;

  assign adv      = !v || dn_ready;
  assign up_ready = adv;

  always_comb begin
    xi = up_data.x;
    yi = up_data.y;
    zi = up_data.z;
    xs = xi >>> STEP;
    ys = yi >>> STEP;
    za = $signed(ZW'(atan_turn(STEP)));
    d_next.cls = up_data.cls;
    if (!yi[CW-1]) begin
      d_next.x = xi + ys;
      d_next.y = yi - xs;
      d_next.z = zi + za;
    end else begin
      d_next.x = xi - ys;
      d_next.y = yi + xs;
      d_next.z = zi - za;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (adv) begin
      v <= up_valid;
    end
    if (adv) begin
      d <= d_next;
    end
  end

  assign dn_valid = v;
  assign dn_data  = d;

  a_x_positive: assert property (@(posedge clk) disable iff (rst)
    v && (d.cls == CLS_NE || d.cls == CLS_SE || d.cls == CLS_SW || d.cls == CLS_NW)
      |-> !d.x[CW-1])
    else $error("cordic x went negative");

endmodule

/* design/cbb_back.sv */
// back end: angle clamp, quadrant restore and rounding to the output width
// depends on cbb_pkg and cbb_brg_if
module cbb_back #(
  parameter int ANGLE_BITS = cbb_pkg::ANGLE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  input  cbb_pkg::cordic_t up_data,
  output logic             up_ready,
  cbb_brg_if.source        result
);
  import cbb_pkg::*;

  localparam int DROP = TURN_BITS - ANGLE_BITS;
  localparam logic [TURN_BITS:0] HALF_LSB = (TURN_BITS + 1)'((64'(1) << DROP) >> 1);
  localparam logic signed [ZW-1:0] QUARTER_Z = $signed({1'b0, QUARTER_TURN});

  // stage a: full-turn angle
  logic                 va;
  logic [TURN_BITS-1:0] frac;
  logic                 same_a;
  logic                 adv_a;

  // stage b: output register
  logic                  vb;
  logic [ANGLE_BITS-1:0] bearing_q;
  logic                  same_q;
  logic                  adv_b;

  logic [TURN_BITS-1:0] t;
  logic [TURN_BITS-1:0] frac_next;
  logic [TURN_BITS:0]   rsum;

  assign adv_b    = !vb || result.ready;
  assign adv_a    = !va || adv_b;
  assign up_ready = adv_a;

  always_comb begin
    if (up_data.z[ZW-1]) begin
      t = '0;
    end else if (up_data.z > QUARTER_Z) begin
      t = QUARTER_TURN;
    end else begin
      t = up_data.z[TURN_BITS-1:0];
    end
    case (up_data.cls)
      CLS_SAME: frac_next = '0;
      CLS_N:    frac_next = '0;
      CLS_E:    frac_next = QUARTER_TURN;
      CLS_S:    frac_next = HALF_TURN;
      CLS_W:    frac_next = THREE_QUARTER_TURN;
      CLS_NE:   frac_next = t;
      CLS_SE:   frac_next = HALF_TURN - t;
      CLS_SW:   frac_next = HALF_TURN + t;
      CLS_NW:   frac_next = '0 - t;
      default:  frac_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv_a) begin
      va <= up_valid;
    end
    if (adv_a) begin
      frac   <= frac_next;
      same_a <= (up_data.cls == CLS_SAME);
    end
  end

  // round half up, carry out of the top wraps the turn
  assign rsum = {1'b0, frac} + HALF_LSB;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (adv_b) begin
      vb <= va;
    end
    if (adv_b) begin
      bearing_q <= rsum[TURN_BITS-1 -: ANGLE_BITS];
      same_q    <= same_a;
    end
  end

  assign result.valid      = vb;
  assign result.bearing    = bearing_q;
  assign result.same_point = same_q;

  a_same_zero: assert property (@(posedge clk) disable iff (rst)
    vb && same_q |-> bearing_q == '0)
    else $error("coincident points without zero bearing");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !vb && !va)
    else $error("result pending right after reset");

  a_same_class: assert property (@(posedge clk) disable iff (rst)
    va && same_a |-> frac == '0)
    else $error("coincident points gave nonzero angle");

endmodule

/* design/compass_bearing_between_points_top.sv */
// top level of the compass bearing block: front end, cordic pipeline, back end
// depends on cbb_pkg, cbb_pts_if, cbb_brg_if, cbb_front, cbb_cordic_stage, cbb_back
//
//   channel  role    word
//   points   sink    target_x, target_y, current_x, current_y (signed 32 bit each)
//   result   source  bearing (ANGLE_BITS, unsigned turn fraction), same_point
//
// one word accepted per cycle while the result is taken; the pipeline has two front stages,
// one stage per cordic iteration and two back stages
// every stage has its own valid bit and takes a word when empty or when the next one moves,
// so a stalled result holds while earlier stages keep filling
// rst is synchronous and clears only the valid bits
module compass_bearing_between_points_top #(
  parameter int CORDIC_STEPS = cbb_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_BITS   = cbb_pkg::ANGLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  cbb_pts_if.sink   points,
  cbb_brg_if.source result
);
  import cbb_pkg::*;

  logic    stg_valid [0:CORDIC_STEPS];
  logic    stg_ready [0:CORDIC_STEPS];
  cordic_t stg_data  [0:CORDIC_STEPS];

  cbb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .points   (points),
    .dn_valid (stg_valid[0]),
    .dn_data  (stg_data[0]),
    .dn_ready (stg_ready[0])
  );

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
    cbb_cordic_stage #(
      .STEP (k)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (stg_valid[k]),
      .up_data  (stg_data[k]),
      .up_ready (stg_ready[k]),
      .dn_valid (stg_valid[k+1]),
      .dn_data  (stg_data[k+1]),
      .dn_ready (stg_ready[k+1])
    );
  end

  cbb_back #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .up_valid (stg_valid[CORDIC_STEPS]),
    .up_data  (stg_data[CORDIC_STEPS]),
    .up_ready (stg_ready[CORDIC_STEPS]),
    .result   (result)
  );

endmodule

/* tb/tb_compass_bearing_between_points_top.sv */
// testbench for compass_bearing_between_points_top: drives point pairs, checks each bearing
// against a table or in-bench cordic; depends on cbb_pkg, cbb_pts_if, cbb_brg_if and the dut
`timescale 1ns / 100ps

module tb_compass_bearing_between_points_top;
  import cbb_pkg::*;

  localparam int CORDIC_STEPS = CORDIC_STEPS_DEF;
  localparam int ANGLE_BITS   = ANGLE_BITS_DEF;
  localparam int DROP_BITS    = TURN_BITS - ANGLE_BITS;
  localparam int NUM_DIR      = 24;
  localparam int NUM_RANDOM   = 1130;
  localparam int NUM_ITEMS    = NUM_DIR + NUM_RANDOM;
  localparam int QUIET_FROM   = NUM_ITEMS - 150;
  localparam int PRESSURE_AT  = 400;
  localparam int HOLD_OFF_LEN = 200;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic signed [COORD_BITS-1:0] CMAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_BITS-1:0] CMIN = 32'sh8000_0000;

  // atan(2^-i) as a fraction of a full turn, 2^32 per turn
  localparam longint ATAN_TURNS [32] = '{
    536870912, 316933406, 167458907, 85004756,
    42667331,  21354465,  10679838,  5340245,
    2670163,   1335087,   667544,    333772,
    166886,    83443,     41722,     20861,
    10430,     5215,      2608,      1304,
    652,       326,       163,       81,
    41,        20,        10,        5,
    3,         1,         1,         0
  };

  typedef struct packed {
    logic signed [COORD_BITS-1:0] tx;
    logic signed [COORD_BITS-1:0] ty;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
  } pts_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] bearing;
    logic                  same_point;
  } brg_t;

  typedef struct packed {
    pts_t pair;
    logic known;
    brg_t want;
  } row_t;

  // known = 1 rows carry their bearing, the rest go through the predictor
  localparam row_t DIR_ROWS [NUM_DIR] = '{
    '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0},    1'b1, '{16'h0000, 1'b1}},
    '{'{CMAX, CMAX, CMAX, CMAX},            1'b1, '{16'h0000, 1'b1}},
    '{'{CMIN, CMIN, CMIN, CMIN},            1'b1, '{16'h0000, 1'b1}},
    '{'{32'sd0, 32'sd1, 32'sd0, 32'sd0},    1'b1, '{16'h0000, 1'b0}},
    '{'{32'sd1, 32'sd0, 32'sd0, 32'sd0},    1'b1, '{16'h4000, 1'b0}},
    '{'{32'sd0, -32'sd1, 32'sd0, 32'sd0},   1'b1, '{16'h8000, 1'b0}},
    '{'{-32'sd1, 32'sd0, 32'sd0, 32'sd0},   1'b1, '{16'hC000, 1'b0}},
    '{'{CMAX, 32'sd5, CMIN, 32'sd5},        1'b1, '{16'h4000, 1'b0}},
    '{'{CMIN, -32'sd7, CMAX, -32'sd7},      1'b1, '{16'hC000, 1'b0}},
    '{'{32'sd3, CMAX, 32'sd3, CMIN},        1'b1, '{16'h0000, 1'b0}},
    '{'{32'sd3, CMIN, 32'sd3, CMAX},        1'b1, '{16'h8000, 1'b0}},
    '{'{32'sd1, 32'sd1, 32'sd0, 32'sd0},    1'b0, '0},
    '{'{32'sd1, -32'sd1, 32'sd0, 32'sd0},   1'b0, '0},
    '{'{-32'sd1, -32'sd1, 32'sd0, 32'sd0},  1'b0, '0},
    '{'{-32'sd1, 32'sd1, 32'sd0, 32'sd0},   1'b0, '0},
    '{'{CMAX, CMAX, CMIN, CMIN},            1'b0, '0},
    '{'{CMIN, CMAX, CMAX, CMIN},            1'b0, '0},
    '{'{CMAX, CMIN, CMIN, CMAX},            1'b0, '0},
    '{'{CMIN, CMIN, CMAX, CMAX},            1'b0, '0},
    '{'{32'sd1, CMAX, 32'sd0, CMIN},        1'b0, '0},
    '{'{CMAX, 32'sd1, CMIN, 32'sd0},        1'b0, '0},
    '{'{-32'sd1, CMAX, 32'sd0, CMIN},       1'b0, '0},
    '{'{32'sd1000, -32'sd577, 32'sd0, 32'sd0}, 1'b0, '0},
    '{'{CMIN, CMIN, 32'sd0, 32'sd0},        1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst;
  logic calm;
  logic hold_off_req;

  brg_t bearing_q [$];
  int   mismatches;
  int   bearings_checked;
  int   coincident_seen;
  int   input_stalls;
  int   cycles;

  cbb_pts_if points ();
  cbb_brg_if #(.ANGLE_BITS(ANGLE_BITS)) result ();

  compass_bearing_between_points_top #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .ANGLE_BITS  (ANGLE_BITS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .points(points),
    .result(result)
  );

  always #6 clk = ~clk;

  function automatic brg_t predict_bearing(input pts_t p);
    longint dx, dy, ax, ay, x, y, z, xs, ys, rnd;
    logic [TURN_BITS-1:0] t, frac;
    brg_t r;
    dx = longint'($signed(p.tx)) - longint'($signed(p.cx));
    dy = longint'($signed(p.ty)) - longint'($signed(p.cy));
    r.same_point = 1'b0;
    if (dx == 0 && dy == 0) begin
      r.bearing    = '0;
      r.same_point = 1'b1;
      return r;
    end
    if (dx == 0) begin
      frac = (dy > 0) ? '0 : HALF_TURN;
    end else if (dy == 0) begin
      frac = (dx > 0) ? QUARTER_TURN : THREE_QUARTER_TURN;
    end else begin
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      // vectoring from north: x holds the north leg, y the east leg
      x = ay << GUARD_SHIFT;
      y = ax << GUARD_SHIFT;
      z = 0;
      for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_TURNS[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_TURNS[i];
        end
      end
      if (z < 0) t = '0;
      else if (z > longint'(QUARTER_TURN)) t = QUARTER_TURN;
      else t = z[TURN_BITS-1:0];
      if (dx > 0 && dy > 0) frac = t;
      else if (dx > 0) frac = HALF_TURN - t;
      else if (dy < 0) frac = HALF_TURN + t;
      else frac = -t;
    end
    // round half up, then wrap at one turn
    rnd = (longint'(frac) + ((longint'(1) << DROP_BITS) >> 1)) >> DROP_BITS;
    r.bearing = rnd[ANGLE_BITS-1:0];
    return r;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] random_span();
    logic signed [COORD_BITS-1:0] v;
    v = $urandom() >> $urandom_range(0, 31);
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  function automatic pts_t random_pair();
    pts_t p;
    int unsigned pick;
    logic signed [COORD_BITS-1:0] ddx, ddy, d;
    p.tx = $urandom();
    p.ty = $urandom();
    p.cx = $urandom();
    p.cy = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 30) return p;
    if (pick < 55) begin
      ddx = $urandom_range(0, 2000) - 1000;
      ddy = $urandom_range(0, 2000) - 1000;
    end else if (pick < 70) begin
      ddx = random_span();
      ddy = random_span();
    end else if (pick < 80) begin
      // close to a diagonal
      d   = $urandom_range(1, 1 << 20);
      ddx = ($urandom_range(0, 1) == 1) ? d : -d;
      d   = d + $urandom_range(0, 2) - 1;
      ddy = ($urandom_range(0, 1) == 1) ? d : -d;
    end else if (pick < 92) begin
      if ($urandom_range(0, 1) == 1) begin
        ddx = '0;
        ddy = random_span();
      end else begin
        ddx = random_span();
        ddy = '0;
      end
    end else begin
      ddx = '0;
      ddy = '0;
    end
    p.tx = p.cx + ddx;
    p.ty = p.cy + ddy;
    return p;
  endfunction

  // sender: directed table first, then random pairs
  initial begin
    pts_t pr;
    int   k;
    rst              <= 1'b1;
    calm             <= 1'b0;
    hold_off_req     <= 1'b0;
    points.valid     <= 1'b0;
    points.target_x  <= '0;
    points.target_y  <= '0;
    points.current_x <= '0;
    points.current_y <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (k = 0; k < NUM_ITEMS; k++) begin
      pr = (k < NUM_DIR) ? DIR_ROWS[k].pair : random_pair();
      if (k < QUIET_FROM && (k % 300) < 200 && $urandom_range(0, 99) < 15) begin
        points.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      calm <= (k >= QUIET_FROM) || ((k % 300) >= 200);
      if (k == PRESSURE_AT) hold_off_req <= 1'b1;
      points.valid     <= 1'b1;
      points.target_x  <= pr.tx;
      points.target_y  <= pr.ty;
      points.current_x <= pr.cx;
      points.current_y <= pr.cy;
      @(posedge clk);
      while (!points.ready) @(posedge clk);
      if (k < NUM_DIR && DIR_ROWS[k].known) bearing_q.push_back(DIR_ROWS[k].want);
      else bearing_q.push_back(predict_bearing(pr));
    end
    points.valid <= 1'b0;
    while (bearing_q.size() != 0) @(posedge clk);
    repeat (CORDIC_STEPS + 8) @(posedge clk);
    $display("sent %0d point pairs (%0d directed), checked %0d bearings, %0d coincident",
             NUM_ITEMS, NUM_DIR, bearings_checked, coincident_seen);
    $display("block held off its input for %0d cycles under output back-pressure",
             input_stalls);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // receiver: checks each word, throttles ready in bursts
  initial begin
    brg_t want;
    int   hold_cnt;
    logic hold_off_done;
    hold_cnt      = 0;
    hold_off_done = 1'b0;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result.valid && result.ready) begin
        if (bearing_q.size() == 0) begin
          $error("bearing word with no pair outstanding: bearing %0d same_point %0d",
                 result.bearing, result.same_point);
          mismatches++;
        end else begin
          want = bearing_q.pop_front();
          bearings_checked++;
          if (result.same_point === 1'b1) coincident_seen++;
          if (result.bearing !== want.bearing) begin
            $error("bearing: expected %0d, got %0d", want.bearing, result.bearing);
            mismatches++;
          end
          if (result.same_point !== want.same_point) begin
            $error("same_point: expected %0d, got %0d", want.same_point, result.same_point);
            mismatches++;
          end
        end
      end
      // one long hold-off lets the pipeline fill and back up into the input
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        hold_cnt      = HOLD_OFF_LEN;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        result.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 8) begin
        hold_cnt = $urandom_range(1, 12) - 1;
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  // watchdog and input stall count
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (!rst && points.valid === 1'b1 && points.ready === 1'b0) input_stalls++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d bearings outstanding", cycles, bearing_q.size());
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule
